/* sv/tcst_pkg.sv */
package tcst_pkg;

    localparam int SLOTS       = 5;
    localparam int HISTORY_LEN = 4;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int PRES_W = $clog2(HISTORY_LEN + 1);
    localparam int WIDE_W = 8;

    localparam logic [1:0] EV_DOWN = 2'd0;
    localparam logic [1:0] EV_MOVE = 2'd1;
    localparam logic [1:0] EV_UP   = 2'd2;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_DOWN    = 2'd1;
    localparam logic [1:0] PH_PRESSED = 2'd2;
    localparam logic [1:0] PH_UP      = 2'd3;

    typedef struct packed {
        logic [7:0]  contact_id;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [1:0]  touch_event;
        logic        frame_ghost;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  slot;
        logic        accepted;
        logic [1:0]  contact_state;
        logic        contact_enabled;
        logic [2:0]  presence_level;
        logic [2:0]  active_contacts;
        logic [15:0] oldest_x;
        logic [15:0] oldest_y;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_RESOLVE,
        ST_UPDATE,
        ST_REPORT
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic resolve;
        logic commit;
    } dp_cmd_t;

endpackage

/* sv/tcst_ctrl.sv */
module tcst_ctrl
    import tcst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    output logic    done,
    output dp_cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:  state_next = ST_RESOLVE;
            ST_RESOLVE: state_next = ST_UPDATE;
            ST_UPDATE:  state_next = ST_REPORT;
            ST_REPORT:  state_next = start ? ST_LOOKUP : ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy        = 1'b1;
        done        = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ST_LOOKUP:  cmd.lookup  = 1'b1;
            ST_RESOLVE: cmd.resolve = 1'b1;
            ST_UPDATE:  cmd.commit  = 1'b1;
            ST_REPORT:
            begin
                busy        = 1'b0;
                done        = 1'b1;
                cmd.capture = start;
            end
            default:    busy = 1'b1;
        endcase
    end

`ifndef SYNTH
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> done)
        else $error("commit not followed by result strobe");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction not followed by busy");
`endif

endmodule

/* sv/tcst_datapath.sv */
module tcst_datapath
    import tcst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dp_cmd_t   cmd,
    input  in_item_t  item,
    output out_item_t result
);

    in_item_t            in_reg;
    logic [SLOTS-1:0]    hit_reg;
    logic [SLOTS-1:0]    free_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic                found_reg;
    logic                claim_reg;

    logic [SLOTS-1:0]    in_use_reg;
    logic [SLOTS-1:0]    en_reg;
    logic [7:0]          contact_reg [SLOTS];
    logic [1:0]          phase_reg   [SLOTS];
    logic [PRES_W-1:0]   pres_reg    [SLOTS];
    logic [15:0]         win_x_reg   [SLOTS][HISTORY_LEN];
    logic [15:0]         win_y_reg   [SLOTS][HISTORY_LEN];
    logic [CNT_W-1:0]    total_reg;
    out_item_t           res_reg;

    logic [SLOTS-1:0]    hit_next;
    logic [SLOTS-1:0]    free_next;
    logic [SLOT_W-1:0]   idx_next;
    logic                found_next;
    logic                claim_next;

    logic                sel_in_use_next;
    logic                sel_en_next;
    logic [1:0]          sel_phase_next;
    logic [PRES_W-1:0]   sel_pres_next;
    logic [15:0]         sel_x_next [HISTORY_LEN];
    logic [15:0]         sel_y_next [HISTORY_LEN];
    logic [CNT_W-1:0]    total_next;
    out_item_t           res_next;
    logic                pos_zero;
    logic                sel_en;
    logic [PRES_W-1:0]   sel_pres;
    logic [WIDE_W-1:0]   wide_idx;
    logic [WIDE_W-1:0]   wide_pres;
    logic [WIDE_W-1:0]   wide_total;

    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            hit_next[s]  = in_use_reg[s] && (contact_reg[s] == in_reg.contact_id);
            free_next[s] = !in_use_reg[s];
        end
    end

    always_comb
    begin
        idx_next   = '0;
        found_next = 1'b0;
        claim_next = 1'b0;
        if (|hit_reg)
        begin
            for (int s = SLOTS - 1; s >= 0; s--)
            begin
                if (hit_reg[s])
                begin
                    idx_next = SLOT_W'(s);
                end
            end
            found_next = !in_reg.frame_ghost;
        end
        else if (|free_reg)
        begin
            for (int s = SLOTS - 1; s >= 0; s--)
            begin
                if (free_reg[s])
                begin
                    idx_next = SLOT_W'(s);
                end
            end
            found_next = !in_reg.frame_ghost;
            claim_next = 1'b1;
        end
    end

    always_comb
    begin
        pos_zero        = (in_reg.x_pos == 16'd0) && (in_reg.y_pos == 16'd0);
        sel_en          = en_reg[idx_reg];
        sel_pres        = pres_reg[idx_reg];
        sel_in_use_next = 1'b1;
        sel_en_next     = sel_en;
        sel_phase_next  = phase_reg[idx_reg];
        total_next      = total_reg;

        if (pos_zero)
        begin
            sel_pres_next = (sel_pres != '0) ? sel_pres - 1'b1 : sel_pres;
        end
        else
        begin
            sel_pres_next = (sel_pres < PRES_W'(HISTORY_LEN)) ? sel_pres + 1'b1 : sel_pres;
        end

        for (int i = 0; i < HISTORY_LEN - 1; i++)
        begin
            sel_x_next[i] = win_x_reg[idx_reg][i+1];
            sel_y_next[i] = win_y_reg[idx_reg][i+1];
        end
        sel_x_next[HISTORY_LEN-1] = in_reg.x_pos;
        sel_y_next[HISTORY_LEN-1] = in_reg.y_pos;

        case (in_reg.touch_event)
            EV_DOWN:
            begin
                if (!sel_en)
                begin
                    sel_phase_next = PH_DOWN;
                    sel_en_next    = 1'b1;
                    total_next     = total_reg + 1'b1;
                end
            end
            EV_MOVE:
            begin
                sel_phase_next = PH_PRESSED;
            end
            EV_UP:
            begin
                if (sel_en && (total_reg != '0))
                begin
                    total_next = total_reg - 1'b1;
                end
                sel_in_use_next = 1'b0;
                sel_en_next     = 1'b0;
                sel_pres_next   = '0;
                sel_phase_next  = PH_UP;
                for (int i = 0; i < HISTORY_LEN; i++)
                begin
                    sel_x_next[i] = '0;
                    sel_y_next[i] = '0;
                end
            end
            default:
            begin
                sel_phase_next = phase_reg[idx_reg];
            end
        endcase

        wide_idx   = WIDE_W'(idx_reg);
        wide_pres  = WIDE_W'(sel_pres_next);
        res_next   = '0;
        if (found_reg)
        begin
            wide_total               = WIDE_W'(total_next);
            res_next.slot            = wide_idx[2:0];
            res_next.accepted        = 1'b1;
            res_next.contact_state   = sel_phase_next;
            res_next.contact_enabled = sel_en_next;
            res_next.presence_level  = wide_pres[2:0];
            res_next.oldest_x        = sel_x_next[0];
            res_next.oldest_y        = sel_y_next[0];
        end
        else
        begin
            wide_total = WIDE_W'(total_reg);
        end
        res_next.active_contacts = wide_total[2:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= item;
        end
        if (cmd.lookup)
        begin
            hit_reg  <= hit_next;
            free_reg <= free_next;
        end
        if (cmd.resolve)
        begin
            idx_reg <= idx_next;
        end
        if (cmd.commit)
        begin
            res_reg <= res_next;
            if (found_reg && claim_reg)
            begin
                contact_reg[idx_reg] <= in_reg.contact_id;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg  <= 1'b0;
            claim_reg  <= 1'b0;
            in_use_reg <= '0;
            en_reg     <= '0;
            total_reg  <= '0;
            for (int s = 0; s < SLOTS; s++)
            begin
                phase_reg[s] <= PH_IDLE;
                pres_reg[s]  <= '0;
                for (int i = 0; i < HISTORY_LEN; i++)
                begin
                    win_x_reg[s][i] <= '0;
                    win_y_reg[s][i] <= '0;
                end
            end
        end
        else
        begin
            if (cmd.resolve)
            begin
                found_reg <= found_next;
                claim_reg <= claim_next;
            end
            if (cmd.commit && found_reg)
            begin
                in_use_reg[idx_reg] <= sel_in_use_next;
                en_reg[idx_reg]     <= sel_en_next;
                phase_reg[idx_reg]  <= sel_phase_next;
                pres_reg[idx_reg]   <= sel_pres_next;
                total_reg           <= total_next;
                for (int i = 0; i < HISTORY_LEN; i++)
                begin
                    win_x_reg[idx_reg][i] <= sel_x_next[i];
                    win_y_reg[idx_reg][i] <= sel_y_next[i];
                end
            end
        end
    end

    assign result = res_reg;

`ifndef SYNTH
    a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(en_reg) == int'(total_reg))
        else $error("enabled count out of step with enable bits");

    a_enabled_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (en_reg & ~in_use_reg) == '0)
        else $error("enabled contact in a free slot");

    a_drop_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !found_reg) |=> $stable(in_use_reg) && $stable(total_reg))
        else $error("dropped transaction changed slot state");
`endif

endmodule

/* sv/touch_contact_slot_tracker.sv */
// An accepted transaction steps through the lookup, resolve, update and report
// states, with busy high until report; the result is registered in update, and
// the next start is taken in the cycle the result is shown.
// Results are strobed by done for one cycle; the receiver cannot stall.
// Reset (rst_n low, asynchronous) frees all slots, clears windows and counts.
module touch_contact_slot_tracker
    import tcst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output logic      done,
    output out_item_t result
);

    dp_cmd_t cmd;

    tcst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    tcst_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .result (result)
    );

endmodule
